FILE: sv/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg: shared types and constants of the MIPS subset execute unit
// Opcodes, function codes, trap codes, event codes, config indices, reset values and register numbers.
// ----------------------------------------------------------------------------
package mse_pkg;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_TRAP    = 6'h1a;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2b;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_MFHI = 6'h10;
    localparam logic [5:0] FN_MFLO = 6'h12;
    localparam logic [5:0] FN_MULT = 6'h18;
    localparam logic [5:0] FN_DIV  = 6'h1a;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_SLT  = 6'h2a;

    localparam logic [3:0] TC_NEWLINE = 4'h0;
    localparam logic [3:0] TC_PRINT   = 4'h1;
    localparam logic [3:0] TC_READ    = 4'h5;
    localparam logic [3:0] TC_HALT    = 4'ha;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_NEWLINE = 3'd1,
        EV_PRINT   = 3'd2,
        EV_READ    = 3'd3,
        EV_HALT    = 3'd4,
        EV_UNKNOWN = 3'd5
    } t_event;

    localparam logic        CFG_START_PC  = 1'b0;
    localparam logic        CFG_DATA_BASE = 1'b1;

    localparam logic [31:0] GP_RESET        = 32'h1000_8000;
    localparam logic [31:0] START_PC_RESET  = 32'h0000_0000;
    localparam logic [31:0] DATA_BASE_RESET = 32'h1000_0000;
    localparam logic [4:0]  REG_GP = 5'd28;
    localparam logic [4:0]  REG_SP = 5'd29;
    localparam logic [4:0]  REG_RA = 5'd31;

endpackage

FILE: sv/mips_subset_execute_unit.sv
// ----------------------------------------------------------------------------
// mips_subset_execute_unit: multicycle MIPS32 subset execute unit
// Executes one instruction word per input word against a register file,
// hi/lo and a word data memory, and reports the next pc and trap flags.
// ----------------------------------------------------------------------------
// Order: a word is accepted, its registers are read (S_READ), it executes (S_EXEC)
// and its result is registered (S_OUT); mult and div, but not a zero divisor, also
// pass the shared 32-step shift unit (adding in S_MUL, subtracting in S_DIV, then
// S_DFIX), and lw waits on memory (S_LOAD, S_LWB). No new word is taken before the
// result leaves S_OUT; a held result stalls the input only once the next result is ready as well.
// Reset is synchronous, active low; a pass through S_CLEAR then loads the registers.
module mips_subset_execute_unit #(
    parameter int DMEM_WORDS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] instruction, [63:32] console_value
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] next_pc, [34:32] trap_event, [66:35] print_value,
    // [67] bad_instruction, [68] memory_error, [69] halted, [71:70] zero
    output logic [71:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int AW = $clog2(DMEM_WORDS);
    localparam logic [31:0] DMEM_BYTES = 32'(DMEM_WORDS) << 2;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_DFIX, S_LOAD, S_LWB, S_OUT
    } t_state;

    t_state      r_state;
    logic [31:0] r_regs [32];
    logic [31:0] r_mem [DMEM_WORDS];
    logic [31:0] r_pc, r_data_base, r_hi, r_lo;
    logic        r_stopped;
    logic [31:0] r_ins, r_console, r_vs, r_vt, r_mdata;
    logic [4:0]  r_cnt;
    logic [31:0] r_acc, r_q;   // partial product/remainder, multiplier/quotient
    logic [31:0] r_div;        // divisor magnitude or multiplicand
    logic [AW-1:0] r_addr;
    logic        r_out_valid;
    logic [71:0] r_out;
    logic [71:0] r_res;

    logic [5:0]  w_op, w_fn;
    logic [4:0]  w_rs, w_rt, w_rd, w_sh;
    logic [31:0] w_simm, w_uimm, w_pc4, w_ea, w_off;
    logic        w_mem_ok;
    logic [32:0] w_sum, w_sub;
    logic        w_load;

    assign w_op   = r_ins[31:26];
    assign w_rs   = r_ins[25:21];
    assign w_rt   = r_ins[20:16];
    assign w_rd   = r_ins[15:11];
    assign w_sh   = r_ins[10:6];
    assign w_fn   = r_ins[5:0];
    assign w_uimm = {16'h0, r_ins[15:0]};
    assign w_simm = {{16{r_ins[15]}}, r_ins[15:0]};
    assign w_pc4  = r_pc + 32'd4;
    assign w_ea   = r_vs + w_simm;
    assign w_off  = w_ea - r_data_base;
    assign w_mem_ok = w_off < DMEM_BYTES;

    // Shared step: add for multiply, trial subtract for divide.
    assign w_sum = {1'b0, r_acc} + {1'b0, r_div};
    assign w_sub = {r_acc[31:0], r_q[31]} - {1'b0, r_div};

    // A finished result moves to the output register once that is free.
    assign w_load = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    assign s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_res;

    function automatic logic [71:0] pack_out(logic [31:0] pc, mse_pkg::t_event ev,
                                             logic [31:0] pv, logic bad, logic merr,
                                             logic halt);
        return {2'b00, halt, merr, bad, pv, ev, pc};
    endfunction

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC && !r_stopped && w_op == mse_pkg::OP_SW && w_mem_ok)
            r_mem[w_off[AW+1:2]] <= r_vt;
        r_mdata <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_res       <= r_out;
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_pc        <= mse_pkg::START_PC_RESET;
            r_data_base <= mse_pkg::DATA_BASE_RESET;
            r_hi        <= '0;
            r_lo        <= '0;
            r_stopped   <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    if (r_cnt == mse_pkg::REG_GP)
                        r_regs[r_cnt] <= mse_pkg::GP_RESET;
                    else if (r_cnt == mse_pkg::REG_SP)
                        r_regs[r_cnt] <= r_data_base + DMEM_BYTES;
                    else
                        r_regs[r_cnt] <= '0;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31)
                        r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        if (i_cfg_index == mse_pkg::CFG_START_PC) begin
                            r_pc <= i_cfg_data;
                        end else begin
                            r_data_base <= i_cfg_data;
                            r_regs[mse_pkg::REG_SP] <= i_cfg_data + DMEM_BYTES;
                        end
                    end else if (s_axis_tvalid && s_axis_tready) begin
                        r_ins     <= s_axis_tdata[31:0];
                        r_console <= s_axis_tdata[63:32];
                        r_state   <= S_READ;
                    end
                end
                S_READ: begin
                    r_vs    <= r_regs[w_rs];
                    r_vt    <= r_regs[w_rt];
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= S_OUT;
                    if (r_stopped) begin
                        r_out <= pack_out(r_pc, mse_pkg::EV_NONE, '0, 1'b0, 1'b0, 1'b1);
                    end else begin
                        r_pc  <= w_pc4;
                        r_out <= pack_out(w_pc4, mse_pkg::EV_NONE, '0, 1'b0, 1'b0, 1'b0);
                        case (w_op)
                            mse_pkg::OP_SPECIAL: begin
                                case (w_fn)
                                    mse_pkg::FN_SLL:
                                        if (w_rd != 5'd0) r_regs[w_rd] <= r_vt << w_sh;
                                    mse_pkg::FN_SRA:
                                        if (w_rd != 5'd0)
                                            r_regs[w_rd] <= $signed(r_vt) >>> w_sh;
                                    mse_pkg::FN_JR: begin
                                        r_pc <= r_vs;
                                        r_out[31:0] <= r_vs;
                                    end
                                    mse_pkg::FN_MFHI:
                                        if (w_rd != 5'd0) r_regs[w_rd] <= r_hi;
                                    mse_pkg::FN_MFLO:
                                        if (w_rd != 5'd0) r_regs[w_rd] <= r_lo;
                                    mse_pkg::FN_MULT: begin
                                        // Unsigned shift/add of magnitudes, sign fixed after.
                                        r_acc   <= '0;
                                        r_q     <= r_vt[31] ? -r_vt : r_vt;
                                        r_div   <= r_vs[31] ? -r_vs : r_vs;
                                        r_cnt   <= '0;
                                        r_state <= S_MUL;
                                    end
                                    mse_pkg::FN_DIV: begin
                                        if (r_vt == 32'd0) begin
                                            r_lo <= 32'hffff_ffff;
                                            r_hi <= r_vs;
                                        end else begin
                                            r_acc   <= '0;
                                            r_q     <= r_vs[31] ? -r_vs : r_vs;
                                            r_div   <= r_vt[31] ? -r_vt : r_vt;
                                            r_cnt   <= '0;
                                            r_state <= S_DIV;
                                        end
                                    end
                                    mse_pkg::FN_ADDU:
                                        if (w_rd != 5'd0) r_regs[w_rd] <= r_vs + r_vt;
                                    mse_pkg::FN_SUBU:
                                        if (w_rd != 5'd0) r_regs[w_rd] <= r_vs - r_vt;
                                    mse_pkg::FN_SLT:
                                        if (w_rd != 5'd0)
                                            r_regs[w_rd] <= {31'd0,
                                                ($signed(r_vs) < $signed(r_vt))};
                                    default: r_out[67] <= 1'b1;
                                endcase
                            end
                            mse_pkg::OP_J, mse_pkg::OP_JAL: begin
                                if (w_op == mse_pkg::OP_JAL)
                                    r_regs[mse_pkg::REG_RA] <= w_pc4;
                                r_pc        <= {w_pc4[31:28], r_ins[25:0], 2'b00};
                                r_out[31:0] <= {w_pc4[31:28], r_ins[25:0], 2'b00};
                            end
                            mse_pkg::OP_BEQ, mse_pkg::OP_BNE: begin
                                if ((r_vs == r_vt) == (w_op == mse_pkg::OP_BEQ)) begin
                                    r_pc        <= w_pc4 + (w_simm << 2);
                                    r_out[31:0] <= w_pc4 + (w_simm << 2);
                                end
                            end
                            mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU:
                                if (w_rt != 5'd0) r_regs[w_rt] <= r_vs + w_simm;
                            mse_pkg::OP_ANDI:
                                if (w_rt != 5'd0) r_regs[w_rt] <= r_vs & w_uimm;
                            mse_pkg::OP_LUI:
                                if (w_rt != 5'd0) r_regs[w_rt] <= {r_ins[15:0], 16'h0};
                            mse_pkg::OP_TRAP: begin
                                case (r_ins[3:0])
                                    mse_pkg::TC_NEWLINE: r_out[34:32] <= mse_pkg::EV_NEWLINE;
                                    mse_pkg::TC_PRINT: begin
                                        r_out[34:32] <= mse_pkg::EV_PRINT;
                                        r_out[66:35] <= r_vs;
                                    end
                                    mse_pkg::TC_READ: begin
                                        r_out[34:32] <= mse_pkg::EV_READ;
                                        if (w_rt != 5'd0) r_regs[w_rt] <= r_console;
                                    end
                                    mse_pkg::TC_HALT: begin
                                        r_out[34:32] <= mse_pkg::EV_HALT;
                                        r_out[69]    <= 1'b1;
                                        r_stopped    <= 1'b1;
                                    end
                                    default: begin
                                        r_out[34:32] <= mse_pkg::EV_UNKNOWN;
                                        r_out[69]    <= 1'b1;
                                        r_stopped    <= 1'b1;
                                    end
                                endcase
                            end
                            mse_pkg::OP_LW, mse_pkg::OP_SW: begin
                                if (!w_mem_ok)
                                    r_out[68] <= 1'b1;
                                else if (w_op == mse_pkg::OP_LW) begin
                                    r_addr  <= w_off[AW+1:2];
                                    r_state <= S_LOAD;
                                end
                            end
                            default: r_out[67] <= 1'b1;
                        endcase
                    end
                end
                S_MUL: begin
                    // {r_acc, r_q} shifts right one bit per step.
                    if (r_q[0])
                        {r_acc, r_q} <= {w_sum, r_q[31:1]};
                    else
                        {r_acc, r_q} <= {1'b0, r_acc, r_q[31:1]};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31)
                        r_state <= S_DFIX;
                end
                S_DIV: begin
                    // Restoring division, one quotient bit per step.
                    if (!w_sub[32]) begin
                        r_acc <= w_sub[31:0];
                        r_q   <= {r_q[30:0], 1'b1};
                    end else begin
                        r_acc <= {r_acc[30:0], r_q[31]};
                        r_q   <= {r_q[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31)
                        r_state <= S_DFIX;
                end
                S_DFIX: begin
                    if (w_fn == mse_pkg::FN_MULT) begin
                        if (r_vs[31] ^ r_vt[31])
                            {r_hi, r_lo} <= -{r_acc, r_q};
                        else
                            {r_hi, r_lo} <= {r_acc, r_q};
                    end else begin
                        r_lo <= (r_vs[31] ^ r_vt[31]) ? -r_q : r_q;
                        r_hi <= r_vs[31] ? -r_acc : r_acc;
                    end
                    r_state <= S_OUT;
                end
                S_LOAD: r_state <= S_LWB;
                S_LWB: begin
                    if (w_rt != 5'd0) r_regs[w_rt] <= r_mdata;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_load)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_input_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready)
        else $error("input accepted while busy");
    a_out_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> r_out_valid)
        else $error("result not presented");
    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_stopped) && $past(r_state) != S_CLEAR |-> r_stopped)
        else $error("halt flag cleared");
    a_r0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) && $past(r_state) != S_CLEAR |-> r_regs[0] == 32'd0)
        else $error("r0 written");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the MIPS subset execute unit
// A scoreboard predicts every result word from its own copy of the register
// file, hi/lo, pc and data memory. Directed words cover the corner cases, and
// random words and memory sequences follow in three phases of idling and
// configuration. The run ends with a halting trap and further words that come back halted.
// ----------------------------------------------------------------------------
module tb;

    // Members run from the top bit down, matching the result word layout.
    typedef struct packed {
        logic            halted;
        logic            merr;
        logic            bad;
        logic [31:0]     pv;
        mse_pkg::t_event ev;
        logic [31:0]     npc;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        cfg_index = mse_pkg::CFG_START_PC;
    logic [31:0] cfg_data = '0;

    mips_subset_execute_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Predicted machine state.
    logic [31:0] cur_pc, base_addr, hi_q, lo_q;
    logic [31:0] gpr [32];
    logic [31:0] dmem [1024];
    bit          dmem_valid [1024];
    int          stored_words [$];
    bit          stopped_q;

    logic [63:0] instr_queue [$];
    t_result     result_queue [$];

    int  tx_idle = 0, rx_idle = 0, rx_hold = 0, fail_count = 0;
    bit  hold_req = 1'b0, hold_seen = 1'b0;
    logic in_fire = 1'b0;

    function automatic void set_reg(input logic [4:0] idx, input logic [31:0] v);
        if (idx != 5'd0) gpr[idx] = v;
    endfunction

    function automatic logic [31:0] r_word(input logic [4:0] rs, input logic [4:0] rt,
                                           input logic [4:0] rd, input logic [4:0] sh,
                                           input logic [5:0] fn);
        return {mse_pkg::OP_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] i_word(input logic [5:0] op, input logic [4:0] rs,
                                           input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // Executes one word on the predicted state and queues it with its result.
    task automatic issue(input logic [31:0] ins, input logic [31:0] con);
        logic [5:0]  op;
        logic [4:0]  rs, rt, rd, sh;
        logic [31:0] simm, vs, vt, pc4, addr, off, ua, ub, q, r;
        logic [63:0] prod;
        t_result     res;
        op = ins[31:26];
        vs = gpr[ins[25:21]];
        addr = vs + {{16{ins[15]}}, ins[15:0]};
        off = addr - base_addr;
        // A load of a word never stored is turned into a store to that word.
        if (!stopped_q && op == mse_pkg::OP_LW && off < 32'd4096 &&
            !dmem_valid[off[11:2]])
            ins[31:26] = mse_pkg::OP_SW;
        op = ins[31:26];
        rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11]; sh = ins[10:6];
        simm = {{16{ins[15]}}, ins[15:0]};
        vt = gpr[rt];
        res = '0;
        res.ev = mse_pkg::EV_NONE;
        if (stopped_q) begin
            res.npc = cur_pc;
            res.halted = 1'b1;
        end else begin
            pc4 = cur_pc + 32'd4;
            cur_pc = pc4;
            case (op)
                mse_pkg::OP_SPECIAL: begin
                    case (ins[5:0])
                        mse_pkg::FN_SLL:  set_reg(rd, vt << sh);
                        mse_pkg::FN_SRA:  set_reg(rd, $signed(vt) >>> sh);
                        mse_pkg::FN_JR:   cur_pc = vs;
                        mse_pkg::FN_MFHI: set_reg(rd, hi_q);
                        mse_pkg::FN_MFLO: set_reg(rd, lo_q);
                        mse_pkg::FN_MULT: begin
                            prod = 64'(longint'($signed(vs)) * longint'($signed(vt)));
                            hi_q = prod[63:32];
                            lo_q = prod[31:0];
                        end
                        mse_pkg::FN_DIV: begin
                            if (vt == 32'd0) begin
                                lo_q = 32'hffff_ffff;
                                hi_q = vs;
                            end else begin
                                ua = vs[31] ? -vs : vs;
                                ub = vt[31] ? -vt : vt;
                                q = ua / ub;
                                r = ua % ub;
                                lo_q = (vs[31] ^ vt[31]) ? -q : q;
                                hi_q = vs[31] ? -r : r;
                            end
                        end
                        mse_pkg::FN_ADDU: set_reg(rd, vs + vt);
                        mse_pkg::FN_SUBU: set_reg(rd, vs - vt);
                        mse_pkg::FN_SLT:  set_reg(rd, {31'd0, $signed(vs) < $signed(vt)});
                        default: res.bad = 1'b1;
                    endcase
                end
                mse_pkg::OP_J:   cur_pc = {pc4[31:28], ins[25:0], 2'b00};
                mse_pkg::OP_JAL: begin
                    set_reg(mse_pkg::REG_RA, pc4);
                    cur_pc = {pc4[31:28], ins[25:0], 2'b00};
                end
                mse_pkg::OP_BEQ:  if (vs == vt) cur_pc = pc4 + (simm << 2);
                mse_pkg::OP_BNE:  if (vs != vt) cur_pc = pc4 + (simm << 2);
                mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU: set_reg(rt, vs + simm);
                mse_pkg::OP_ANDI: set_reg(rt, vs & {16'd0, ins[15:0]});
                mse_pkg::OP_LUI:  set_reg(rt, {ins[15:0], 16'd0});
                mse_pkg::OP_TRAP: begin
                    case (ins[3:0])
                        mse_pkg::TC_NEWLINE: res.ev = mse_pkg::EV_NEWLINE;
                        mse_pkg::TC_PRINT: begin
                            res.ev = mse_pkg::EV_PRINT;
                            res.pv = vs;
                        end
                        mse_pkg::TC_READ: begin
                            res.ev = mse_pkg::EV_READ;
                            set_reg(rt, con);
                        end
                        mse_pkg::TC_HALT: begin
                            res.ev = mse_pkg::EV_HALT;
                            stopped_q = 1'b1;
                        end
                        default: begin
                            res.ev = mse_pkg::EV_UNKNOWN;
                            stopped_q = 1'b1;
                        end
                    endcase
                end
                mse_pkg::OP_LW: begin
                    if (off < 32'd4096) set_reg(rt, dmem[off[11:2]]);
                    else res.merr = 1'b1;
                end
                mse_pkg::OP_SW: begin
                    if (off < 32'd4096) begin
                        dmem[off[11:2]] = vt;
                        if (!dmem_valid[off[11:2]]) stored_words.push_back(off[11:2]);
                        dmem_valid[off[11:2]] = 1'b1;
                    end else begin
                        res.merr = 1'b1;
                    end
                end
                default: res.bad = 1'b1;
            endcase
            res.npc = cur_pc;
            res.halted = stopped_q;
        end
        instr_queue.push_back({con, ins});
        result_queue.push_back(res);
    endtask

    // Loads a register through lui/addiu, then issues a load or store at addr.
    task automatic mem_access(input logic [5:0] op, input logic [31:0] addr);
        logic [4:0]  rb, rt;
        logic [15:0] imm;
        logic [31:0] b, upper;
        rb = 5'($urandom_range(31, 1));
        rt = 5'($urandom);
        imm = 16'($urandom);
        b = addr - {{16{imm[15]}}, imm};
        upper = b - {{16{b[15]}}, b[15:0]};
        issue(i_word(mse_pkg::OP_LUI, 5'd0, rb, upper[31:16]), $urandom);
        issue(i_word(mse_pkg::OP_ADDIU, rb, rb, b[15:0]), $urandom);
        issue(i_word(op, rb, rt, imm), $urandom);
    endtask

    task automatic random_item();
        logic [31:0] w;
        logic [5:0]  fns [10];
        logic [5:0]  iops [4];
        fns = '{mse_pkg::FN_SLL, mse_pkg::FN_SRA, mse_pkg::FN_JR, mse_pkg::FN_MFHI,
                mse_pkg::FN_MFLO, mse_pkg::FN_MULT, mse_pkg::FN_DIV,
                mse_pkg::FN_ADDU, mse_pkg::FN_SUBU, mse_pkg::FN_SLT};
        iops = '{mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU, mse_pkg::OP_ANDI, mse_pkg::OP_LUI};
        w = $urandom;
        case ($urandom_range(11))
            0, 1: issue(r_word(w[25:21], w[20:16], w[15:11], w[10:6],
                               fns[$urandom_range(9)]), $urandom);
            2: issue(i_word(iops[$urandom_range(3)], w[25:21], w[20:16], w[15:0]),
                     $urandom);
            3: issue(i_word($urandom_range(1) ? mse_pkg::OP_BEQ : mse_pkg::OP_BNE,
                            w[25:21], $urandom_range(1) ? w[25:21] : w[20:16],
                            w[15:0]), $urandom);
            4: issue({$urandom_range(1) ? mse_pkg::OP_J : mse_pkg::OP_JAL, w[25:0]},
                     $urandom);
            5: begin
                w[3:0] = ($urandom_range(2) == 0) ? mse_pkg::TC_NEWLINE :
                         ($urandom_range(1) ? mse_pkg::TC_PRINT : mse_pkg::TC_READ);
                issue({mse_pkg::OP_TRAP, w[25:0]}, $urandom);
            end
            6, 7: mem_access(mse_pkg::OP_SW, base_addr + 32'($urandom_range(4095)));
            8: begin
                if (stored_words.size() == 0)
                    mem_access(mse_pkg::OP_SW, base_addr + 32'($urandom_range(4095)));
                else
                    mem_access(mse_pkg::OP_LW, base_addr +
                               32'(stored_words[$urandom_range(stored_words.size() - 1)] * 4
                                   + $urandom_range(3)));
            end
            9: mem_access($urandom_range(1) ? mse_pkg::OP_LW : mse_pkg::OP_SW,
                          base_addr + 32'd4096 + 32'($urandom_range(32'hffff_efff)));
            default: begin
                // Arbitrary word; any trap is turned into a print, so no trap halts.
                if (w[31:26] == mse_pkg::OP_TRAP) w[3:0] = mse_pkg::TC_PRINT;
                issue(w, $urandom);
            end
        endcase
    endtask

    task automatic wait_idle();
        while (instr_queue.size() != 0 || result_queue.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [31:0] v);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid = 1'b0;
        if (idx == mse_pkg::CFG_START_PC) begin
            cur_pc = v;
        end else begin
            base_addr = v;
            gpr[mse_pkg::REG_SP] = v + 32'd4096;
        end
    endtask

    // Input side: a new word is offered only once the current one is taken.
    always @(posedge i_clk) in_fire <= s_tvalid && s_axis_tready;

    always @(negedge i_clk) begin
        if (i_rst_n && (!s_tvalid || in_fire)) begin
            if (instr_queue.size() != 0 && $urandom_range(99) >= tx_idle) begin
                s_tdata <= instr_queue.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // A toggle of hold_req starts a long stretch with the output side held off.
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            rx_hold <= 400;
            m_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_tready) begin
            got = m_axis_tdata[69:0];
            if (result_queue.size() == 0) begin
                $display("%0t: unexpected word, actual %h", $time, m_axis_tdata);
                fail_count <= fail_count + 1;
            end else begin
                want = result_queue.pop_front();
                if (got.npc !== want.npc || got.ev !== want.ev || got.pv !== want.pv ||
                    got.bad !== want.bad || got.merr !== want.merr ||
                    got.halted !== want.halted || m_axis_tdata[71:70] !== 2'b00) begin
                    $display("%0t: mismatch pc/ev/print/bad/merr/halt expected %h %0d %h %b%b%b",
                             $time, want.npc, want.ev, want.pv, want.bad, want.merr,
                             want.halted);
                    $display("%0t:                          actual   %h %0d %h %b%b%b",
                             $time, got.npc, got.ev, got.pv, got.bad, got.merr, got.halted);
                    fail_count <= fail_count + 1;
                end
            end
        end
    end

    initial begin
        #8_000_000;
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        cur_pc = mse_pkg::START_PC_RESET;
        base_addr = mse_pkg::DATA_BASE_RESET;
        hi_q = '0;
        lo_q = '0;
        stopped_q = 1'b0;
        foreach (gpr[i]) gpr[i] = '0;
        foreach (dmem_valid[i]) dmem_valid[i] = 1'b0;
        gpr[mse_pkg::REG_GP] = mse_pkg::GP_RESET;
        gpr[mse_pkg::REG_SP] = mse_pkg::DATA_BASE_RESET + 32'd4096;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_cfg(mse_pkg::CFG_START_PC, $urandom & 32'hffff_fffc);
        write_cfg(mse_pkg::CFG_DATA_BASE, mse_pkg::DATA_BASE_RESET);
        tx_idle = 30;
        rx_idle = 62;

        // Directed corner cases.
        issue(i_word(mse_pkg::OP_LUI, 5'd0, 5'd1, 16'h8000), 0);
        issue(i_word(mse_pkg::OP_ADDIU, 5'd0, 5'd2, 16'hffff), 0);
        issue(r_word(5'd1, 5'd2, 5'd0, 5'd0, mse_pkg::FN_DIV), 0);   // overflow
        issue(r_word(5'd0, 5'd0, 5'd3, 5'd0, mse_pkg::FN_MFLO), 0);
        issue(r_word(5'd0, 5'd0, 5'd4, 5'd0, mse_pkg::FN_MFHI), 0);
        issue(r_word(5'd2, 5'd0, 5'd0, 5'd0, mse_pkg::FN_DIV), 0);   // divide by zero
        issue(r_word(5'd0, 5'd0, 5'd3, 5'd0, mse_pkg::FN_MFLO), 0);
        issue(r_word(5'd1, 5'd1, 5'd0, 5'd0, mse_pkg::FN_MULT), 0);
        issue(r_word(5'd0, 5'd0, 5'd4, 5'd0, mse_pkg::FN_MFHI), 0);
        issue(r_word(5'd0, 5'd2, 5'd5, 5'd31, mse_pkg::FN_SLL), 0);
        issue(r_word(5'd0, 5'd1, 5'd6, 5'd31, mse_pkg::FN_SRA), 0);
        issue(r_word(5'd2, 5'd2, 5'd0, 5'd0, mse_pkg::FN_ADDU), 0);  // r0 stays zero
        issue(r_word(5'd1, 5'd2, 5'd7, 5'd0, mse_pkg::FN_SLT), 0);
        issue(r_word(5'd1, 5'd2, 5'd8, 5'd0, mse_pkg::FN_SUBU), 0);
        issue(i_word(mse_pkg::OP_SW, mse_pkg::REG_SP, 5'd2, 16'hfffc), 0);
        issue(i_word(mse_pkg::OP_LW, mse_pkg::REG_SP, 5'd9, 16'hfffc), 0);
        issue(i_word(mse_pkg::OP_SW, mse_pkg::REG_SP, 5'd2, 16'h0000), 0); // just past the end
        issue(i_word(mse_pkg::OP_LW, mse_pkg::REG_GP, 5'd9, 16'h0000), 0);
        issue(i_word(mse_pkg::OP_ANDI, 5'd2, 5'd10, 16'hffff), 0);
        issue(i_word(mse_pkg::OP_BEQ, 5'd2, 5'd2, 16'h8000), 0);
        issue(i_word(mse_pkg::OP_BNE, 5'd1, 5'd2, 16'h7fff), 0);
        issue({mse_pkg::OP_JAL, 26'h3ff_ffff}, 0);
        issue(r_word(mse_pkg::REG_RA, 5'd0, 5'd0, 5'd0, mse_pkg::FN_JR), 0);
        issue(i_word(mse_pkg::OP_TRAP, 5'd0, 5'd0, {12'd0, mse_pkg::TC_NEWLINE}), 0);
        issue(i_word(mse_pkg::OP_TRAP, 5'd1, 5'd0, {12'd0, mse_pkg::TC_PRINT}), 0);
        issue(i_word(mse_pkg::OP_TRAP, 5'd0, 5'd0, {12'd0, mse_pkg::TC_READ}),
              32'h8000_0000);
        issue(i_word(mse_pkg::OP_TRAP, 5'd0, 5'd11, {12'd0, mse_pkg::TC_READ}),
              32'h7fff_ffff);
        issue(r_word(5'd1, 5'd2, 5'd3, 5'd0, 6'h3f), 0);            // unknown function
        issue(i_word(6'h3f, 5'd1, 5'd2, 16'h1234), 0);              // unknown opcode

        // The output side holds off long enough for the input to stall.
        hold_req = ~hold_req;
        for (int n = 0; n < 320; n++) random_item();
        wait_idle();

        write_cfg(mse_pkg::CFG_START_PC, 32'hffff_ffff);
        write_cfg(mse_pkg::CFG_DATA_BASE, 32'hffff_ffff);
        tx_idle = 62;
        rx_idle = 30;
        for (int n = 0; n < 320; n++) random_item();
        wait_idle();

        write_cfg(mse_pkg::CFG_DATA_BASE, 32'h0000_0000);
        write_cfg(mse_pkg::CFG_START_PC, 32'h0000_0000);
        tx_idle = 0;
        rx_idle = 0;
        for (int n = 0; n < 320; n++) random_item();
        issue(i_word(mse_pkg::OP_TRAP, 5'd0, 5'd0,
                     {12'($urandom), $urandom_range(1) ? mse_pkg::TC_HALT : 4'hf}), 0);
        for (int n = 0; n < 10; n++) issue($urandom, $urandom);
        wait_idle();

        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
